// ===== rtl/opi_pkg.sv =====
`default_nettype none

package opi_pkg;

  // Heading resolution and the fraction width of the cosine and sine used for motion.
  localparam int unsigned HEADING_BITS   = 32;
  localparam int unsigned TRIG_FRAC_BITS = 15;

  // Shared multiplier operand width: wide enough for speed times a rounded cosine.
  localparam int unsigned MUL_W  = (TRIG_FRAC_BITS + 17 > 33) ? TRIG_FRAC_BITS + 17 : 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Fixed widths of the trig datapath (Q30 arithmetic on a 32-bit binary angle).
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned RED_W  = 30;
  localparam int unsigned TRIG_W = 31;
  localparam int unsigned QUO_W  = 28;
  localparam int unsigned ROT_W  = TRIG_FRAC_BITS + 2;
  localparam int unsigned QUAT_W = 16;

  // Position update widths and shifts.
  localparam int unsigned POSE_W    = 48;
  localparam int unsigned STEP_W    = 33;
  localparam int unsigned POS_SHIFT = TRIG_FRAC_BITS + 4;
  localparam int unsigned DH_SHIFT  = 40 - HEADING_BITS;

  localparam logic [TRIG_W-1:0] Q30_ONE  = 31'h4000_0000;
  localparam logic [RED_W-1:0]  OCT_HALF = 30'h2000_0000;
  // Low 32 bits of pi in Q31; the remaining integer part is added as the plain angle r.
  localparam logic [31:0]       PI_FRAC  = 32'd2451551556;
  localparam logic signed [31:0] Q15_BIAS = 32'sd16384;
  localparam logic signed [16:0] Q15_PLUS_ONE = 17'sd32768;
  localparam logic signed [QUAT_W-1:0] Q15_MAX = 16'sh7FFF;

  localparam logic signed [POSE_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [POSE_W-1:0] POS_MIN = 48'sh8000_0000_0000;

  // Exact reciprocals for the Taylor divisors: floor(n / d) == (n * m) >> k for n < 2^30.
  // Terms 0 to 3 serve the sine series, terms 4 to 7 the cosine series.
  localparam logic [31:0] RCP_MUL [8] = '{
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12)
  };
  localparam logic [5:0] RCP_SHIFT [8] = '{
    6'd37, 6'd36, 6'd35, 6'd33, 6'd37, 6'd36, 6'd35, 6'd34
  };

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,
    ST_XMUL,
    ST_XSET,
    ST_X2MUL,
    ST_X2SET,
    ST_DMUL,
    ST_DSET,
    ST_TMUL,
    ST_SMUL,
    ST_SSET,
    ST_CSET,
    ST_TEND,
    ST_CMUL,
    ST_PXMUL,
    ST_PXSET,
    ST_PYMUL,
    ST_PYSET,
    ST_HSET
  } opi_state_e;

  // Operand pairs of the shared multiplier.
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_R_K,
    MOP_X_X,
    MOP_N_RCP,
    MOP_X2_T,
    MOP_X_T,
    MOP_V_COS,
    MOP_P_DT,
    MOP_V_SIN,
    MOP_W_DT
  } opi_mop_e;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    opi_mop_e mop;
    logic     ld_in;
    logic     ld_red;
    logic     ld_x;
    logic     ld_x2;
    logic     ld_t;
    logic     ld_s;
    logic     ld_c;
    logic     ld_rot;
    logic     ld_px;
    logic     ld_py;
    logic     ld_hd;
    logic     ld_out;
    logic     term_clr;
    logic     term_inc;
  } opi_ctrl_t;

  // Add a position step and clamp to the signed 48-bit range.
  function automatic logic signed [POSE_W-1:0] pose_add(
    input logic signed [POSE_W-1:0] pose,
    input logic signed [STEP_W-1:0] step
  );
    logic signed [POSE_W:0] sum;
    sum = (POSE_W + 1)'(pose) + (POSE_W + 1)'(step);
    if (sum[POSE_W] != sum[POSE_W-1]) begin
      return sum[POSE_W] ? POS_MIN : POS_MAX;
    end
    return sum[POSE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/odometry_pose_integrator.sv =====
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_stall_o    linear_speed_i, angular_rate_i, elapsed_time_i
// out      out  out_valid_o / out_stall_i  position_x_o, position_y_o, heading_angle_o,
//                                          quaternion_z_o, quaternion_w_o, speed_echo_o,
//                                          rate_echo_o
//
// A transaction is taken in the idle state and then occupies the datapath until its result is
// loaded, so the input takes no new transaction while the sequencer is busy.
// All arithmetic runs through one shared 33 x 33 multiplier: the two cosine/sine evaluations
// (old heading, then half the new heading) and, between them, the pose update.
// The result sits in an output register; a new transaction is taken while it waits, and the
// next result is held in the last step until that register is free.
// Reset (rst_ni low) clears pose and heading to zero and empties the output register.

`default_nettype none

module odometry_pose_integrator
  import opi_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [15:0]           linear_speed_i,
  input  wire logic signed [23:0]           angular_rate_i,
  input  wire logic        [19:0]           elapsed_time_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [POSE_W-1:0]          position_x_o,
  output logic signed [POSE_W-1:0]          position_y_o,
  output logic        [ANG_W-1:0]           heading_angle_o,
  output logic signed [QUAT_W-1:0]          quaternion_z_o,
  output logic signed [QUAT_W-1:0]          quaternion_w_o,
  output logic signed [15:0]                speed_echo_o,
  output logic signed [23:0]                rate_echo_o
);

  // Control state.
  opi_state_e state_q, state_d;
  opi_ctrl_t  ctrl;
  logic       phase_q;
  logic [2:0] term_q;
  logic       out_valid_q;
  logic       out_free;

  // Pose state.
  logic signed [POSE_W-1:0]   pose_x_q;
  logic signed [POSE_W-1:0]   pose_y_q;
  logic [HEADING_BITS-1:0]    heading_q;

  // Captured transaction.
  logic signed [15:0] v_q;
  logic signed [23:0] w_q;
  logic [19:0]        dt_q;

  // Trig datapath registers.
  logic [RED_W-1:0]  r_q;
  logic [1:0]        quad_q;
  logic              swap_q;
  logic [RED_W-1:0]  x_q;
  logic [RED_W-1:0]  x2_q;
  logic [TRIG_W-1:0] t_q;
  logic [TRIG_W-1:0] s_q;
  logic [TRIG_W-1:0] c_q;
  logic signed [ROT_W-1:0] cos_q;
  logic signed [ROT_W-1:0] sin_q;

  // Shared multiplier.
  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] prod_q;

  // Combinational datapath values.
  logic [ANG_W-1:0]   h32;
  logic [ANG_W-1:0]   ang;
  logic [RED_W-1:0]   red_raw;
  logic               red_swap;
  logic [RED_W-1:0]   red_val;
  logic [PROD_W-1:0]  x_sum;
  logic [PROD_W-1:0]  x2_sum;
  logic [RED_W-1:0]   x_d;
  logic [RED_W-1:0]   div_n;
  logic [QUO_W-1:0]   quo;
  logic [TRIG_W-1:0]  sw_c;
  logic [TRIG_W-1:0]  sw_s;
  logic signed [31:0] pc;
  logic signed [31:0] ps;
  logic signed [31:0] co;
  logic signed [31:0] si;
  logic signed [31:0] co_bias;
  logic signed [31:0] si_bias;
  logic signed [31:0] qw_bias;
  logic signed [31:0] qz_bias;
  logic signed [16:0] qw_full;
  logic signed [16:0] qz_full;
  logic signed [QUAT_W-1:0] qw_d;
  logic signed [QUAT_W-1:0] qz_d;
  logic signed [STEP_W-1:0] step;

  // Output registers.
  logic signed [POSE_W-1:0] pos_x_out_q;
  logic signed [POSE_W-1:0] pos_y_out_q;
  logic [ANG_W-1:0]         heading_out_q;
  logic signed [QUAT_W-1:0] qz_out_q;
  logic signed [QUAT_W-1:0] qw_out_q;
  logic signed [15:0]       speed_out_q;
  logic signed [23:0]       rate_out_q;

  assign out_free = !(out_valid_q && out_stall_i);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_RED;
      ST_RED:   state_d = ST_XMUL;
      ST_XMUL:  state_d = ST_XSET;
      ST_XSET:  state_d = ST_X2MUL;
      ST_X2MUL: state_d = ST_X2SET;
      ST_X2SET: state_d = ST_DMUL;
      ST_DMUL:  state_d = ST_DSET;
      ST_DSET:  state_d = (term_q == 3'd3) ? ST_SMUL : ST_TMUL;
      ST_TMUL:  state_d = (term_q == 3'd7) ? ST_CSET : ST_DMUL;
      ST_SMUL:  state_d = ST_SSET;
      ST_SSET:  state_d = ST_DMUL;
      ST_CSET:  state_d = ST_TEND;
      ST_TEND: begin
        if (!phase_q) begin
          state_d = ST_CMUL;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CMUL:  state_d = ST_PXMUL;
      ST_PXMUL: state_d = ST_PXSET;
      ST_PXSET: state_d = ST_PYMUL;
      ST_PYMUL: state_d = ST_PYSET;
      ST_PYSET: state_d = ST_HSET;
      ST_HSET:  state_d = ST_RED;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control word for each state.
  always_comb begin
    ctrl     = '0;
    ctrl.mop = MOP_NONE;
    unique case (state_q)
      ST_IDLE:  ctrl.ld_in = in_valid_i;
      ST_RED: begin
        ctrl.ld_red   = 1'b1;
        ctrl.term_clr = 1'b1;
      end
      ST_XMUL:  ctrl.mop = MOP_R_K;
      ST_XSET:  ctrl.ld_x = 1'b1;
      ST_X2MUL: ctrl.mop = MOP_X_X;
      ST_X2SET: ctrl.ld_x2 = 1'b1;
      ST_DMUL:  ctrl.mop = MOP_N_RCP;
      ST_DSET:  ctrl.ld_t = 1'b1;
      ST_TMUL: begin
        ctrl.mop      = MOP_X2_T;
        ctrl.term_inc = (term_q != 3'd7);
      end
      ST_SMUL:  ctrl.mop = MOP_X_T;
      ST_SSET: begin
        ctrl.ld_s     = 1'b1;
        ctrl.term_inc = 1'b1;
      end
      ST_CSET:  ctrl.ld_c = 1'b1;
      ST_TEND: begin
        ctrl.ld_rot = !phase_q;
        ctrl.ld_out = phase_q && out_free;
      end
      ST_CMUL:  ctrl.mop = MOP_V_COS;
      ST_PXMUL: ctrl.mop = MOP_P_DT;
      ST_PXSET: begin
        ctrl.ld_px = 1'b1;
        ctrl.mop   = MOP_V_SIN;
      end
      ST_PYMUL: ctrl.mop = MOP_P_DT;
      ST_PYSET: begin
        ctrl.ld_py = 1'b1;
        ctrl.mop   = MOP_W_DT;
      end
      ST_HSET:  ctrl.ld_hd = 1'b1;
      default:  ctrl.mop = MOP_NONE;
    endcase
  end

  // Angle reduction to an octant: the first phase uses the old heading, the second half the new.
  assign h32      = ANG_W'(heading_q) << (ANG_W - HEADING_BITS);
  assign ang      = phase_q ? (h32 >> 1) : h32;
  assign red_raw  = ang[RED_W-1:0];
  assign red_swap = red_raw > OCT_HALF;
  assign red_val  = red_swap ? RED_W'(Q30_ONE - TRIG_W'(red_raw)) : red_raw;

  // Radians in Q30 and its square, both rounded.
  assign x_sum  = prod_q + (PROD_W'(1) << 31);
  assign x_d    = r_q + x_sum[32 +: RED_W];
  assign x2_sum = prod_q + (PROD_W'(1) << 29);

  // Dividend of a Taylor term: x^2 for the first term of a series, else the last product.
  assign div_n = (term_q[1:0] == 2'd0) ? x2_q : prod_q[30 +: RED_W];
  assign quo   = prod_q[RCP_SHIFT[term_q] +: QUO_W];

  // Multiplier operand selection.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctrl.mop)
      MOP_R_K: begin
        op_a = MUL_W'(r_q);
        op_b = MUL_W'(PI_FRAC);
      end
      MOP_X_X: begin
        op_a = MUL_W'(x_q);
        op_b = MUL_W'(x_q);
      end
      MOP_N_RCP: begin
        op_a = MUL_W'(div_n);
        op_b = MUL_W'(RCP_MUL[term_q]);
      end
      MOP_X2_T: begin
        op_a = MUL_W'(x2_q);
        op_b = MUL_W'(t_q);
      end
      MOP_X_T: begin
        op_a = MUL_W'(x_q);
        op_b = MUL_W'(t_q);
      end
      MOP_V_COS: begin
        op_a = MUL_W'(v_q);
        op_b = MUL_W'(cos_q);
      end
      MOP_P_DT: begin
        op_a = prod_q[MUL_W-1:0];
        op_b = MUL_W'(dt_q);
      end
      MOP_V_SIN: begin
        op_a = MUL_W'(v_q);
        op_b = MUL_W'(sin_q);
      end
      MOP_W_DT: begin
        op_a = MUL_W'(w_q);
        op_b = MUL_W'(dt_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(op_a) * PROD_W'(op_b);

  // Undo the octant swap and place the result in its quadrant.
  assign sw_c = swap_q ? s_q : c_q;
  assign sw_s = swap_q ? c_q : s_q;
  assign pc   = $signed({1'b0, sw_c});
  assign ps   = $signed({1'b0, sw_s});

  always_comb begin
    case (quad_q)
      2'd0: begin
        co = pc;
        si = ps;
      end
      2'd1: begin
        co = -ps;
        si = pc;
      end
      2'd2: begin
        co = -pc;
        si = -ps;
      end
      default: begin
        co = ps;
        si = -pc;
      end
    endcase
  end

  // Round half up to the motion fraction width.
  assign co_bias = co + (32'sd1 <<< (29 - TRIG_FRAC_BITS));
  assign si_bias = si + (32'sd1 <<< (29 - TRIG_FRAC_BITS));

  // Round half up to Q1.15 and clamp plus one.
  assign qw_bias = co + Q15_BIAS;
  assign qz_bias = si + Q15_BIAS;
  assign qw_full = qw_bias[15 +: 17];
  assign qz_full = qz_bias[15 +: 17];
  assign qw_d    = (qw_full == Q15_PLUS_ONE) ? Q15_MAX : qw_full[QUAT_W-1:0];
  assign qz_d    = (qz_full == Q15_PLUS_ONE) ? Q15_MAX : qz_full[QUAT_W-1:0];

  // Position step, floor of the product shifted down.
  assign step = prod_q[POS_SHIFT +: STEP_W];

  // Control and pose registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      term_q      <= '0;
      out_valid_q <= 1'b0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      heading_q   <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.ld_in) begin
        phase_q <= 1'b0;
      end else if (ctrl.ld_hd) begin
        phase_q <= 1'b1;
      end
      if (ctrl.term_clr) begin
        term_q <= '0;
      end else if (ctrl.term_inc) begin
        term_q <= term_q + 3'd1;
      end
      if (ctrl.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl.ld_px) begin
        pose_x_q <= pose_add(pose_x_q, step);
      end
      if (ctrl.ld_py) begin
        pose_y_q <= pose_add(pose_y_q, step);
      end
      if (ctrl.ld_hd) begin
        heading_q <= heading_q + prod_q[DH_SHIFT +: HEADING_BITS];
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_in) begin
      v_q  <= linear_speed_i;
      w_q  <= angular_rate_i;
      dt_q <= elapsed_time_i;
    end
    if (ctrl.ld_red) begin
      r_q    <= red_val;
      swap_q <= red_swap;
      quad_q <= ang[ANG_W-1 -: 2];
    end
    if (ctrl.mop != MOP_NONE) begin
      prod_q <= prod_d;
    end
    if (ctrl.ld_x) begin
      x_q <= x_d;
    end
    if (ctrl.ld_x2) begin
      x2_q <= x2_sum[30 +: RED_W];
    end
    if (ctrl.ld_t) begin
      t_q <= Q30_ONE - TRIG_W'(quo);
    end
    if (ctrl.ld_s) begin
      s_q <= prod_q[30 +: TRIG_W];
    end
    if (ctrl.ld_c) begin
      c_q <= Q30_ONE - TRIG_W'(prod_q[31 +: 29]);
    end
    if (ctrl.ld_rot) begin
      cos_q <= co_bias[(30 - TRIG_FRAC_BITS) +: ROT_W];
      sin_q <= si_bias[(30 - TRIG_FRAC_BITS) +: ROT_W];
    end
    if (ctrl.ld_out) begin
      pos_x_out_q   <= pose_x_q;
      pos_y_out_q   <= pose_y_q;
      heading_out_q <= h32;
      qz_out_q      <= qz_d;
      qw_out_q      <= qw_d;
      speed_out_q   <= v_q;
      rate_out_q    <= w_q;
    end
  end

  // Ports.
  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign position_x_o    = pos_x_out_q;
  assign position_y_o    = pos_y_out_q;
  assign heading_angle_o = heading_out_q;
  assign quaternion_z_o  = qz_out_q;
  assign quaternion_w_o  = qw_out_q;
  assign speed_echo_o    = speed_out_q;
  assign rate_echo_o     = rate_out_q;

endmodule

`default_nettype wire

// ===== rtl/opi_checker.sv =====
`default_nettype none

module opi_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_i,
  input wire logic               out_valid_i,
  input wire logic               out_stall_i,
  input wire logic signed [47:0] position_x_i,
  input wire logic signed [47:0] position_y_i,
  input wire logic [31:0]        heading_angle_i,
  input wire logic signed [15:0] quaternion_z_i
);

  // A result that is held back keeps its pose.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(position_x_i) &&
      $stable(position_y_i) && $stable(heading_angle_i))
    else $error("result changed while stalled");

  // The block is busy right after it takes a transaction.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input not stalled after a transaction");

  // A fresh result appears only as the block returns to idle.
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_stall_i)
    else $error("result appeared while busy");

  // Half the heading lies in the upper half plane, so its sine is never negative.
  a_quat_z_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !quaternion_z_i[15])
    else $error("negative quaternion z");

endmodule

bind odometry_pose_integrator opi_checker u_opi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_i      (in_stall_o),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .position_x_i    (position_x_o),
  .position_y_i    (position_y_o),
  .heading_angle_i (heading_angle_o),
  .quaternion_z_i  (quaternion_z_o)
);

`default_nettype wire

// ===== tb/tb_odometry_pose_integrator.sv =====
`timescale 1ns / 100ps

module tb_odometry_pose_integrator;
  import opi_pkg::*;

  localparam int DIR_ROWS       = 22;
  localparam int RAND_PER_PHASE = 232;
  localparam int NUM_PHASES     = 4;
  localparam int TAIL_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [63:0] UNIT_Q30  = 64'd1 << 30;
  localparam logic [63:0] PI_Q31_FX = 64'd6746518852;

  // One pose report as it leaves the block.
  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] speed;
    logic signed [23:0] rate;
  } pose_result_t;

  // One row of the directed table; want holds a hand-derived pose where typed is set.
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [23:0] rate;
    logic        [19:0] dt;
    logic               typed;
    pose_result_t       want;
  } tick_row_t;

  typedef struct packed {
    logic signed [63:0] cos_q30;
    logic signed [63:0] sin_q30;
  } cos_sin_t;

  localparam pose_result_t NO_POSE = '0;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] linear_speed = '0;
  logic signed [23:0] angular_rate = '0;
  logic        [19:0] elapsed_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [47:0] position_x;
  logic signed [47:0] position_y;
  logic        [31:0] heading_angle;
  logic signed [15:0] quaternion_z;
  logic signed [15:0] quaternion_w;
  logic signed [15:0] speed_echo;
  logic signed [23:0] rate_echo;

  // Hand-derived expectation that travels with the current input transaction.
  logic         tick_typed = 1'b0;
  pose_result_t tick_want  = '0;

  // Predicted pose state; the heading is kept as a left-aligned 32-bit binary angle.
  longint      track_x = 0;
  longint      track_y = 0;
  logic [31:0] track_heading = '0;

  pose_result_t pending_poses[$];
  tick_row_t    dir_rows[DIR_ROWS];

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;
  int fail_count    = 0;
  int ticks_in      = 0;
  int poses_out     = 0;
  int heading_wraps = 0;

  odometry_pose_integrator u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .linear_speed_i  (linear_speed),
    .angular_rate_i  (angular_rate),
    .elapsed_time_i  (elapsed_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .position_x_o    (position_x),
    .position_y_o    (position_y),
    .heading_angle_o (heading_angle),
    .quaternion_z_o  (quaternion_z),
    .quaternion_w_o  (quaternion_w),
    .speed_echo_o    (speed_echo),
    .rate_echo_o     (rate_echo)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cosine and sine of a binary angle in signed Q30, by octant folding and Taylor series.
  function automatic cos_sin_t cos_sin_q30(input logic [31:0] ang);
    logic [63:0] r, x, x2, ts, tc, s, c, hold;
    logic        mirror;
    cos_sin_t    res;
    r = {34'd0, ang[29:0]};
    mirror = r > (64'd1 << 29);
    if (mirror) begin
      r = UNIT_Q30 - r;
    end
    x  = (r * PI_Q31_FX + (64'd1 << 31)) >> 32;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = UNIT_Q30 - ((x2 * UNIT_Q30) >> 30) / 64'd72;
    ts = UNIT_Q30 - ((x2 * ts) >> 30) / 64'd42;
    ts = UNIT_Q30 - ((x2 * ts) >> 30) / 64'd20;
    ts = UNIT_Q30 - ((x2 * ts) >> 30) / 64'd6;
    s  = (x * ts) >> 30;
    tc = UNIT_Q30 - ((x2 * UNIT_Q30) >> 30) / 64'd90;
    tc = UNIT_Q30 - ((x2 * tc) >> 30) / 64'd56;
    tc = UNIT_Q30 - ((x2 * tc) >> 30) / 64'd30;
    tc = UNIT_Q30 - ((x2 * tc) >> 30) / 64'd12;
    c  = UNIT_Q30 - ((x2 * tc) >> 30) / 64'd2;
    if (mirror) begin
      hold = c;
      c = s;
      s = hold;
    end
    // Unfold the quadrant.
    case (ang[31:30])
      2'd0: begin
        res.cos_q30 = $signed(c);
        res.sin_q30 = $signed(s);
      end
      2'd1: begin
        res.cos_q30 = -$signed(s);
        res.sin_q30 = $signed(c);
      end
      2'd2: begin
        res.cos_q30 = -$signed(c);
        res.sin_q30 = -$signed(s);
      end
      default: begin
        res.cos_q30 = $signed(s);
        res.sin_q30 = -$signed(c);
      end
    endcase
    return res;
  endfunction

  // Round a signed Q30 value half up to frac fraction bits.
  function automatic longint round_q30_to(input longint v, input int unsigned frac);
    return (v + (longint'(1) << (29 - frac))) >>> (30 - frac);
  endfunction

  function automatic longint clamp_pose(input longint v);
    if (v > longint'(POS_MAX)) begin
      return longint'(POS_MAX);
    end
    if (v < longint'(POS_MIN)) begin
      return longint'(POS_MIN);
    end
    return v;
  endfunction

  // Advance the tracked pose by one tick and return the pose report it produces.
  function automatic pose_result_t advance_pose(input logic signed [15:0] spd,
                                                input logic signed [23:0] rt,
                                                input logic [19:0] el);
    cos_sin_t     cs;
    longint       dt_l, cos_m, sin_m, dh, qz, qw;
    logic [31:0]  h_new;
    pose_result_t res;
    dt_l = el;
    // Motion uses the heading from before this tick.
    cs = cos_sin_q30(track_heading);
    cos_m = round_q30_to(cs.cos_q30, TRIG_FRAC_BITS);
    sin_m = round_q30_to(cs.sin_q30, TRIG_FRAC_BITS);
    track_x = clamp_pose(track_x + ((longint'(spd) * cos_m * dt_l) >>> POS_SHIFT));
    track_y = clamp_pose(track_y + ((longint'(spd) * sin_m * dt_l) >>> POS_SHIFT));
    // Heading step, floored, then wrapped.
    dh = (longint'(rt) * dt_l) >>> DH_SHIFT;
    h_new = track_heading + (32'(dh) << (32 - HEADING_BITS));
    if ((dh > 0 && h_new < track_heading) || (dh < 0 && h_new > track_heading)) begin
      heading_wraps++;
    end
    track_heading = h_new;
    // Quaternion from half the new heading; only +1.0 needs clamping.
    cs = cos_sin_q30({1'b0, h_new[31:1]});
    qz = round_q30_to(cs.sin_q30, 15);
    qw = round_q30_to(cs.cos_q30, 15);
    if (qz > longint'(Q15_MAX)) begin
      qz = longint'(Q15_MAX);
    end
    if (qw > longint'(Q15_MAX)) begin
      qw = longint'(Q15_MAX);
    end
    res.pos_x   = track_x[47:0];
    res.pos_y   = track_y[47:0];
    res.heading = h_new;
    res.quat_z  = qz[15:0];
    res.quat_w  = qw[15:0];
    res.speed   = spd;
    res.rate    = rt;
    return res;
  endfunction

  task automatic report_fail(input string what, input pose_result_t want,
                             input pose_result_t seen);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t ERROR %s", $realtime, what);
      $display("  expected x=%0d y=%0d h=%h qz=%0d qw=%0d v=%0d w=%0d", want.pos_x,
               want.pos_y, want.heading, want.quat_z, want.quat_w, want.speed, want.rate);
      $display("  actual   x=%0d y=%0d h=%h qz=%0d qw=%0d v=%0d w=%0d", seen.pos_x,
               seen.pos_y, seen.heading, seen.quat_z, seen.quat_w, seen.speed, seen.rate);
    end
  endtask

  // Sample both channels at the rising edge: predict on input, check on output.
  always @(posedge clk) begin : monitor
    pose_result_t seen;
    pose_result_t want;
    logic         took;
    if (rst_n) begin
      took = 1'b0;
      if (in_valid && !in_stall) begin
        want = advance_pose(linear_speed, angular_rate, elapsed_time);
        pending_poses.push_back(tick_typed ? tick_want : want);
        ticks_in++;
        took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        seen.pos_x   = position_x;
        seen.pos_y   = position_y;
        seen.heading = heading_angle;
        seen.quat_z  = quaternion_z;
        seen.quat_w  = quaternion_w;
        seen.speed   = speed_echo;
        seen.rate    = rate_echo;
        poses_out++;
        took = 1'b1;
        if (pending_poses.size() == 0) begin
          report_fail("pose report with no tick pending", NO_POSE, seen);
        end else begin
          want = pending_poses.pop_front();
          if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
              seen.heading !== want.heading || seen.quat_z !== want.quat_z ||
              seen.quat_w !== want.quat_w || seen.speed !== want.speed ||
              seen.rate !== want.rate) begin
            report_fail("pose report mismatch", want, seen);
          end
        end
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
    end
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Drive one input transaction, with random gaps ahead of it, and wait until it is taken.
  task automatic send_tick(input logic signed [15:0] spd, input logic signed [23:0] rt,
                           input logic [19:0] el, input logic typed, input pose_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    linear_speed <= spd;
    angular_rate <= rt;
    elapsed_time <= el;
    tick_typed   <= typed;
    tick_want    <= want;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Hold the sender off until every pending pose report has come back.
  task automatic wait_for_poses();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending_poses.size() != 0);
  endtask

  initial begin : stimulus
    int                 send_pcts[NUM_PHASES];
    int                 stall_pcts[NUM_PHASES];
    logic signed [15:0] spd;
    logic signed [23:0] rt;
    logic        [19:0] el;

    send_pcts  = '{0, 70, 0, 28};
    stall_pcts = '{0, 0, 70, 28};

    // From reset: a zero-time tick, full forward and reverse speed along x, a floored
    // heading step that wraps below zero (quaternion w at -1.0) and one that wraps back.
    dir_rows[0]  = {16'sd0, 24'sd0, 20'd0, 1'b1,
                    {48'd0, 48'd0, 32'h0, 16'sd0, Q15_MAX, 16'sd0, 24'sd0}};
    dir_rows[1]  = {16'sh7FFF, 24'sd0, 20'd16, 1'b1,
                    {48'd32767, 48'd0, 32'h0, 16'sd0, Q15_MAX, 16'sh7FFF, 24'sd0}};
    dir_rows[2]  = {16'sh8000, 24'sd0, 20'd16, 1'b1,
                    {48'hFFFF_FFFF_FFFF, 48'd0, 32'h0, 16'sd0, Q15_MAX, 16'sh8000, 24'sd0}};
    dir_rows[3]  = {16'sd0, 24'shFF_FFFF, 20'd1, 1'b1,
                    {48'hFFFF_FFFF_FFFF, 48'd0, 32'hFFFF_FFFF, 16'sd0, 16'sh8000, 16'sd0,
                     24'shFF_FFFF}};
    dir_rows[4]  = {16'sd0, 24'sd1, 20'd255, 1'b1,
                    {48'hFFFF_FFFF_FFFF, 48'd0, 32'hFFFF_FFFF, 16'sd0, 16'sh8000, 16'sd0,
                     24'sd1}};
    dir_rows[5]  = {16'sd0, 24'sd1, 20'd256, 1'b1,
                    {48'hFFFF_FFFF_FFFF, 48'd0, 32'h0, 16'sd0, Q15_MAX, 16'sd0, 24'sd1}};
    // Eighth-turn steps walk the heading through every octant boundary back to zero.
    for (int i = 6; i < 14; i++) begin
      dir_rows[i] = {16'sd1000, 24'sd4194304, 20'd32768, 1'b0, NO_POSE};
    end
    // Extremes of rate, speed and elapsed time, then a few odd values.
    dir_rows[14] = {16'sd0, 24'sh80_0000, 20'hFFFFF, 1'b0, NO_POSE};
    dir_rows[15] = {16'sd0, 24'sh7F_FFFF, 20'hFFFFF, 1'b0, NO_POSE};
    dir_rows[16] = {16'sh7FFF, 24'sd0, 20'hFFFFF, 1'b0, NO_POSE};
    dir_rows[17] = {16'sh8000, 24'sh7F_FFFF, 20'hFFFFF, 1'b0, NO_POSE};
    dir_rows[18] = {16'sh8000, 24'sh80_0000, 20'hFFFFF, 1'b0, NO_POSE};
    dir_rows[19] = {16'sh7FFF, 24'sd2097152, 20'd32768, 1'b0, NO_POSE};
    dir_rows[20] = {16'shFFFF, 24'shFF_FFFF, 20'd1, 1'b0, NO_POSE};
    dir_rows[21] = {16'sd12345, 24'shC0_0001, 20'd777777, 1'b0, NO_POSE};

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_tick(dir_rows[i].speed, dir_rows[i].rate, dir_rows[i].dt, dir_rows[i].typed,
                dir_rows[i].want);
    end
    wait_for_poses();

    // Random ticks under each handshake mix, draining between phases.
    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = send_pcts[p];
      stall_pct     = stall_pcts[p];
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0:       spd = 16'sh7FFF;
          1:       spd = 16'sh8000;
          2:       spd = '0;
          3, 4:    spd = 16'($signed($urandom_range(200)) - 100);
          default: spd = 16'($urandom);
        endcase
        case ($urandom_range(9))
          0:       rt = 24'sh7F_FFFF;
          1:       rt = 24'sh80_0000;
          2, 3:    rt = 24'($signed($urandom_range(2000)) - 1000);
          default: rt = 24'($urandom);
        endcase
        case ($urandom_range(9))
          0:       el = '0;
          1:       el = 20'hFFFFF;
          2, 3:    el = 20'($urandom_range(1023));
          default: el = 20'($urandom);
        endcase
        send_tick(spd, rt, el, 1'b0, NO_POSE);
      end
      wait_for_poses();
    end

    stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d ticks (%0d from the directed table) and checked %0d pose reports.",
             ticks_in, DIR_ROWS, poses_out);
    $display("Four handshake mixes, %0d heading wraps, %0d failures.", heading_wraps,
             fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // End the run if no transaction moves on either channel for too long.
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("Watchdog expired with %0d pose reports outstanding.", pending_poses.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/opi_pkg.sv
rtl/odometry_pose_integrator.sv
rtl/opi_checker.sv
tb/tb_odometry_pose_integrator.sv
